### rtl/tbfm_pkg.sv
// Package for the triple-buffer frame mailbox.
// Holds the word types, action and register codes, and fixed field widths.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tbfm_pkg;

    localparam int SLOT_COUNT = 3;
    localparam int DIM_W      = 16;
    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 32;

    typedef logic [1:0] t_slot;

    // Action codes. Code three behaves as status only.
    localparam logic [1:0] ACT_PUBLISH = 2'd0;
    localparam logic [1:0] ACT_TAKE    = 2'd1;

    // Configuration register indexes.
    localparam logic [1:0] REG_BASE_ZERO = 2'd0;
    localparam logic [1:0] REG_BASE_ONE  = 2'd1;
    localparam logic [1:0] REG_BASE_TWO  = 2'd2;

    // Slot reset roles.
    localparam t_slot SLOT_ZERO = 2'd0;
    localparam t_slot SLOT_ONE  = 2'd1;
    localparam t_slot SLOT_TWO  = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
    } t_in_word;

    typedef struct packed {
        logic              take_valid;
        t_slot             taken_slot;
        logic [ADDR_W-1:0] taken_address;
        logic [DIM_W-1:0]  taken_width;
        logic [DIM_W-1:0]  taken_height;
        logic [CNT_W-1:0]  taken_sequence;
        logic              overwrote_unread;
        t_slot             write_slot_index;
        logic [ADDR_W-1:0] write_slot_address;
        logic              frame_pending;
        logic [CNT_W-1:0]  publish_total;
        logic [CNT_W-1:0]  drop_total;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the input word
        logic exec;   // apply the captured action and register the result
    } t_dp_cmd;

endpackage

`default_nettype wire

### rtl/tbfm_ctrl.sv
// Controller of the triple-buffer frame mailbox.
// Sequences accept, execute and result strobe; depends on tbfm_pkg.
`default_nettype none

module tbfm_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    output tbfm_pkg::t_dp_cmd  o_cmd,
    output logic               o_done
);
    import tbfm_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_EXEC);
        end
    end

    assign busy       = (r_state != ST_IDLE);
    assign o_cmd.load = start && (r_state == ST_IDLE);
    assign o_cmd.exec = (r_state == ST_EXEC);
    assign o_done     = r_done;

endmodule

`default_nettype wire

### rtl/tbfm_datapath.sv
// Datapath of the triple-buffer frame mailbox: slot roles, metadata,
// counters, base address registers and the result register. Uses tbfm_pkg.
`default_nettype none

module tbfm_datapath #(
    parameter int DIMENSION_BITS = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  tbfm_pkg::t_dp_cmd          i_cmd,
    input  tbfm_pkg::t_in_word         i_word,
    input  wire                        i_cfg_we,
    input  wire  [1:0]                 i_cfg_index,
    input  wire  [31:0]                i_cfg_data,
    output tbfm_pkg::t_out_word        o_result
);
    import tbfm_pkg::*;

    // Stored dimensions keep only their low DIMENSION_BITS bits, at most DIM_W.
    localparam int STORE_W = (DIMENSION_BITS < DIM_W) ? DIMENSION_BITS : DIM_W;

    logic [ADDR_W-1:0]  r_base [SLOT_COUNT];
    logic [STORE_W-1:0] r_slot_w [SLOT_COUNT];
    logic [STORE_W-1:0] r_slot_h [SLOT_COUNT];
    logic [CNT_W-1:0]   r_slot_seq [SLOT_COUNT];

    t_slot            r_writer, r_middle, r_reader;
    t_slot            n_writer, n_middle, n_reader;
    logic             r_fresh, n_fresh;
    logic [CNT_W-1:0] r_seq, n_seq;
    logic [CNT_W-1:0] r_pub, n_pub;
    logic [CNT_W-1:0] r_drop, n_drop;
    t_in_word         r_word;
    t_out_word        r_out, n_out;
    logic             meta_we;

    function automatic logic [ADDR_W-1:0] base_of(input t_slot s,
                                                  input logic [ADDR_W-1:0] b0,
                                                  input logic [ADDR_W-1:0] b1,
                                                  input logic [ADDR_W-1:0] b2);
        logic [ADDR_W-1:0] a;
        case (s)
            SLOT_ZERO: a = b0;
            SLOT_ONE:  a = b1;
            SLOT_TWO:  a = b2;
            default:   a = '0;
        endcase
        return a;
    endfunction

    function automatic logic [STORE_W-1:0] i_word_w_trunc(input logic [DIM_W-1:0] v);
        return v[STORE_W-1:0];
    endfunction

    always_comb begin
        n_writer = r_writer;
        n_middle = r_middle;
        n_reader = r_reader;
        n_fresh  = r_fresh;
        n_seq    = r_seq;
        n_pub    = r_pub;
        n_drop   = r_drop;
        meta_we  = 1'b0;
        n_out    = '0;
        case (r_word.action)
            ACT_PUBLISH: begin
                n_seq    = r_seq + 1'b1;
                meta_we  = (r_writer < SLOT_COUNT);
                n_writer = r_middle;
                n_middle = r_writer;
                n_pub    = r_pub + 1'b1;
                if (r_fresh) begin
                    n_drop = r_drop + 1'b1;
                    n_out.overwrote_unread = 1'b1;
                end
                n_fresh = 1'b1;
            end
            ACT_TAKE: begin
                if (r_fresh) begin
                    n_middle = r_reader;
                    n_reader = r_middle;
                    n_fresh  = 1'b0;
                    n_out.take_valid    = 1'b1;
                    n_out.taken_slot    = r_middle;
                    n_out.taken_address = base_of(r_middle, r_base[0], r_base[1],
                                                  r_base[2]);
                    if (r_middle < SLOT_COUNT) begin
                        n_out.taken_width    = DIM_W'(r_slot_w[r_middle]);
                        n_out.taken_height   = DIM_W'(r_slot_h[r_middle]);
                        n_out.taken_sequence = r_slot_seq[r_middle];
                    end
                end
            end
            default: begin
            end
        endcase
        n_out.write_slot_index   = n_writer;
        n_out.write_slot_address = base_of(n_writer, r_base[0], r_base[1], r_base[2]);
        n_out.frame_pending      = n_fresh;
        n_out.publish_total      = n_pub;
        n_out.drop_total         = n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_writer <= SLOT_ZERO;
            r_middle <= SLOT_ONE;
            r_reader <= SLOT_TWO;
            r_fresh  <= 1'b0;
            r_seq    <= '0;
            r_pub    <= '0;
            r_drop   <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_base[i]     <= '0;
                r_slot_w[i]   <= '0;
                r_slot_h[i]   <= '0;
                r_slot_seq[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BASE_ZERO: r_base[0] <= i_cfg_data;
                    REG_BASE_ONE:  r_base[1] <= i_cfg_data;
                    REG_BASE_TWO:  r_base[2] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec) begin
                r_writer <= n_writer;
                r_middle <= n_middle;
                r_reader <= n_reader;
                r_fresh  <= n_fresh;
                r_seq    <= n_seq;
                r_pub    <= n_pub;
                r_drop   <= n_drop;
                if (meta_we) begin
                    r_slot_w[r_writer]   <= i_word_w_trunc(r_word.frame_width);
                    r_slot_h[r_writer]   <= i_word_w_trunc(r_word.frame_height);
                    r_slot_seq[r_writer] <= n_seq;
                end
            end
        end
    end

    // Input capture and result register carry payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_word;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;

endmodule

`default_nettype wire

### rtl/triple_buffer_frame_mailbox.sv
// Top level of the triple-buffer frame mailbox.
// Joins tbfm_ctrl and tbfm_datapath; uses tbfm_pkg.
`default_nettype none

// Triple-buffer frame mailbox between one producer and one consumer. A
// command word is accepted at a rising edge where start is high and busy is
// low. In the cycle after acceptance the action is applied to the slot
// roles, metadata and counters, and in the cycle after that the result word
// appears on o_result, marked by o_result_valid for exactly one cycle. busy
// is low again in that same result cycle, so a new command can be accepted
// there. The controller's single execute state lies between the
// input capture register and the result register. The receiver cannot stall
// the block: a result must be taken in the cycle it is shown. Publish (action
// zero) stores the frame size and the next sequence number in the writer slot
// and swaps writer and middle; take (action one) swaps reader and middle when
// a fresh frame waits and reports that frame; any other action only reports
// status. The three slot base addresses are written through the configuration
// port, which is always ready; write them only while the block is idle.
module triple_buffer_frame_mailbox #(
    parameter int DIMENSION_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    output logic                  busy,
    input  tbfm_pkg::t_in_word    i_cmd,
    output logic                  o_result_valid,
    output tbfm_pkg::t_out_word   o_result,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [1:0]            i_cfg_index,
    input  wire  [31:0]           i_cfg_data
);
    import tbfm_pkg::*;

    t_dp_cmd dp_cmd;

    assign o_cfg_ready = 1'b1;

    tbfm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (dp_cmd),
        .o_done  (o_result_valid)
    );

    tbfm_datapath #(
        .DIMENSION_BITS (DIMENSION_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_word      (i_cmd),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result)
    );

    // An accepted command is followed by its result word, marked by o_result_valid.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_result_valid)
        else $error("result word missing after accepted command");

    // The slot handed to the reader is never the slot the producer writes.
    a_take_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.take_valid) |->
        (o_result.taken_slot != o_result.write_slot_index))
        else $error("reader and writer share a slot");

    // A successful take always consumes the pending frame.
    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.take_valid) |-> !o_result.frame_pending)
        else $error("frame still pending after take");

    // A publish always leaves a frame pending, and a drop only comes from one.
    a_publish_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.overwrote_unread) |->
        (o_result.frame_pending && !o_result.take_valid))
        else $error("drop reported without pending publish");

endmodule

`default_nettype wire

### verif/tb_triple_buffer_frame_mailbox.sv
// Self-checking testbench for the triple-buffer frame mailbox.
// Drives command and configuration words and predicts every result word.
// Depends on tbfm_pkg and triple_buffer_frame_mailbox.

module tb_triple_buffer_frame_mailbox;

    import tbfm_pkg::*;

    // Action codes that the package leaves unnamed. Both only report status.
    localparam logic [1:0] ACT_STATUS   = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    // Register index past the last slot base. Writes to it must be ignored.
    localparam logic [1:0] REG_SPARE = 2'd3;

    // Mailbox predictor. It mirrors the slot roles, per-slot metadata,
    // counters and base addresses, and keeps the result words still owed by
    // the block in the order the commands were accepted.
    class frame_mailbox_book;
        t_slot             writer_slot;
        t_slot             middle_slot;
        t_slot             reader_slot;
        bit                middle_fresh;
        logic [CNT_W-1:0]  frame_seq;
        logic [CNT_W-1:0]  publishes;
        logic [CNT_W-1:0]  drops;
        logic [DIM_W-1:0]  slot_w [SLOT_COUNT];
        logic [DIM_W-1:0]  slot_h [SLOT_COUNT];
        logic [CNT_W-1:0]  slot_seq [SLOT_COUNT];
        logic [ADDR_W-1:0] base_addr [SLOT_COUNT];
        t_out_word         owed_words [$];
        int                mismatches;

        function new();
            int i;
            for (i = 0; i < SLOT_COUNT; i++) begin
                slot_w[i]    = '0;
                slot_h[i]    = '0;
                slot_seq[i]  = '0;
                base_addr[i] = '0;
            end
            writer_slot  = SLOT_ZERO;
            middle_slot  = SLOT_ONE;
            reader_slot  = SLOT_TWO;
            middle_fresh = 1'b0;
            frame_seq    = '0;
            publishes    = '0;
            drops        = '0;
            mismatches   = 0;
        endfunction

        function void write_base(logic [1:0] index, logic [31:0] data);
            if (index < SLOT_COUNT) begin
                base_addr[index] = data;
            end
        endfunction

        function logic [ADDR_W-1:0] slot_address(t_slot s);
            return (s < SLOT_COUNT) ? base_addr[s] : '0;
        endfunction

        // Applies one accepted command word and queues the result it owes.
        function void note_command(t_in_word cmd);
            t_out_word w;
            t_slot     swap;
            w = '0;
            if (cmd.action == ACT_PUBLISH) begin
                frame_seq = frame_seq + 1;
                slot_w[writer_slot]   = cmd.frame_width;
                slot_h[writer_slot]   = cmd.frame_height;
                slot_seq[writer_slot] = frame_seq;
                swap        = middle_slot;
                middle_slot = writer_slot;
                writer_slot = swap;
                publishes   = publishes + 1;
                if (middle_fresh) begin
                    drops = drops + 1;
                    w.overwrote_unread = 1'b1;
                end
                middle_fresh = 1'b1;
            end else if (cmd.action == ACT_TAKE && middle_fresh) begin
                swap         = middle_slot;
                middle_slot  = reader_slot;
                reader_slot  = swap;
                middle_fresh = 1'b0;
                w.take_valid     = 1'b1;
                w.taken_slot     = reader_slot;
                w.taken_address  = slot_address(reader_slot);
                w.taken_width    = slot_w[reader_slot];
                w.taken_height   = slot_h[reader_slot];
                w.taken_sequence = slot_seq[reader_slot];
            end
            w.write_slot_index   = writer_slot;
            w.write_slot_address = slot_address(writer_slot);
            w.frame_pending      = middle_fresh;
            w.publish_total      = publishes;
            w.drop_total         = drops;
            owed_words.push_back(w);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        // Checks one result word against the oldest owed word.
        function void check_result(t_out_word got);
            t_out_word want;
            if (owed_words.size() == 0) begin
                mismatches++;
                $display("%0t: result word expected none actual %h", $time, got);
                return;
            end
            want = owed_words.pop_front();
            compare("take_valid", want.take_valid, got.take_valid);
            compare("taken_slot", want.taken_slot, got.taken_slot);
            compare("taken_address", want.taken_address, got.taken_address);
            compare("taken_width", want.taken_width, got.taken_width);
            compare("taken_height", want.taken_height, got.taken_height);
            compare("taken_sequence", want.taken_sequence, got.taken_sequence);
            compare("overwrote_unread", want.overwrote_unread, got.overwrote_unread);
            compare("write_slot_index", want.write_slot_index, got.write_slot_index);
            compare("write_slot_address", want.write_slot_address,
                    got.write_slot_address);
            compare("frame_pending", want.frame_pending, got.frame_pending);
            compare("publish_total", want.publish_total, got.publish_total);
            compare("drop_total", want.drop_total, got.drop_total);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    t_in_word    i_cmd          = '0;
    logic        o_result_valid;
    t_out_word   o_result;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index    = '0;
    logic [31:0] i_cfg_data     = '0;

    frame_mailbox_book book = new();

    triple_buffer_frame_mailbox dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Every handshake is observed here, at the edge that completes it. All
    // inputs change by nonblocking assignment, so the values read here are
    // the ones the block saw at this edge. A result shown at this edge
    // belongs to an earlier command, so it is checked before a command
    // accepted at the same edge is applied to the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid) begin
                book.check_result(o_result);
            end
            if (start && !busy) begin
                book.note_command(i_cmd);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                book.write_base(i_cfg_index, i_cfg_data);
            end
        end
    end

    // Presents one command word and holds it until the block takes it. The
    // sender then rests at random with start low; with a nonzero idle share
    // those rests fall on both the execute and the result cycle of the block.
    // start is left high when no rest follows, so back-to-back words never
    // drop it within one time step.
    task automatic send_word(input logic [1:0] action, input logic [15:0] w,
                             input logic [15:0] h, input int idle_pct);
        t_in_word word;
        int       gap;
        word.action       = action;
        word.frame_width  = w;
        word.frame_height = h;
        i_cmd <= word;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        gap = 0;
        while (gap < 24 && $urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Lowers start and waits until every owed result word has come back.
    // Each command yields exactly one result, so an empty queue means the
    // block is idle.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (book.owed_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [1:0] index, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes all three slot bases, then a stray write past the last slot.
    task automatic program_bases(input logic [31:0] b0, input logic [31:0] b1,
                                 input logic [31:0] b2, input logic [31:0] stray);
        put_reg(REG_BASE_ZERO, b0);
        put_reg(REG_BASE_ONE, b1);
        put_reg(REG_BASE_TWO, b2);
        put_reg(REG_SPARE, stray);
        i_cfg_valid <= 1'b0;
    endtask

    // Frame sizes lean on the all-zero and all-one corners.
    function automatic logic [15:0] pick_dim();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random command words. Publishes and takes dominate so the slot roles
    // rotate constantly, with runs of publishes producing drops and runs of
    // takes finding nothing fresh. Status and the spare action are mixed in.
    task automatic random_phase(input int count, input int idle_pct);
        int         n;
        int         r;
        logic [1:0] act;
        for (n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 40) begin
                act = ACT_PUBLISH;
            end else if (r < 75) begin
                act = ACT_TAKE;
            end else if (r < 88) begin
                act = ACT_STATUS;
            end else begin
                act = ACT_RESERVED;
            end
            send_word(act, pick_dim(), pick_dim(), idle_pct);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bases are still at their reset value of zero here. A take before
        // any publish finds nothing fresh; the first publish carries
        // sequence one and its take reads slot zero at address zero.
        send_word(ACT_STATUS, 16'hFFFF, 16'hFFFF, 0);
        send_word(ACT_TAKE, 16'hFFFF, 16'hFFFF, 0);
        send_word(ACT_PUBLISH, 16'h0000, 16'h0000, 0);
        send_word(ACT_TAKE, 16'h0000, 16'h0000, 0);
        settle();
        program_bases(32'hFFFF_FFFF, 32'h0000_0000, 32'hA5A5_5A5A, 32'h1234_5678);

        // Directed words: dimension extremes, publishes over unread frames,
        // a take with nothing fresh, and status words whose sizes must be
        // ignored, including the spare action code.
        send_word(ACT_PUBLISH, 16'hFFFF, 16'hFFFF, 0);
        send_word(ACT_PUBLISH, 16'h5555, 16'hAAAA, 0);
        send_word(ACT_PUBLISH, 16'hAAAA, 16'h5555, 0);
        send_word(ACT_TAKE, 16'h0000, 16'h0000, 0);
        send_word(ACT_TAKE, 16'hFFFF, 16'h0000, 0);
        send_word(ACT_STATUS, 16'h1234, 16'h4321, 0);
        send_word(ACT_RESERVED, 16'hFFFF, 16'hFFFF, 0);
        send_word(ACT_PUBLISH, 16'h0001, 16'h8000, 0);
        send_word(ACT_TAKE, 16'h0000, 16'h0000, 0);
        send_word(ACT_PUBLISH, 16'h8000, 16'h0001, 0);
        send_word(ACT_STATUS, 16'h0000, 16'h0000, 0);
        send_word(ACT_TAKE, 16'h0000, 16'h0000, 0);
        send_word(ACT_TAKE, 16'h0000, 16'h0000, 0);
        send_word(ACT_RESERVED, 16'h0000, 16'h0000, 0);
        send_word(ACT_PUBLISH, 16'hFFFF, 16'h0000, 0);
        send_word(ACT_PUBLISH, 16'h0000, 16'hFFFF, 0);
        send_word(ACT_TAKE, 16'h0000, 16'h0000, 0);
        settle();

        // Random phases: back to back, sender idle in most cycles, back to
        // back again, then idle in about a third. Bases change between
        // phases while the block is idle, the extremes among them.
        program_bases($urandom, $urandom, $urandom, $urandom);
        random_phase(200, 0);
        settle();
        program_bases(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        random_phase(200, 62);
        settle();
        program_bases($urandom, $urandom, $urandom, 32'h0000_0000);
        random_phase(200, 0);
        settle();
        program_bases(32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE, $urandom);
        random_phase(200, 32);
        settle();

        if (book.mismatches == 0 && book.owed_words.size() == 0) begin
            $display("tb_triple_buffer_frame_mailbox passed");
        end else begin
            $display("tb_triple_buffer_frame_mailbox failed");
        end
        $finish;
    end

    // The timeout allows far more time than the whole run needs.
    initial begin
        #400000;
        $display("tb_triple_buffer_frame_mailbox failed");
        $finish;
    end

endmodule

### filelist.f
rtl/tbfm_pkg.sv
rtl/tbfm_ctrl.sv
rtl/tbfm_datapath.sv
rtl/triple_buffer_frame_mailbox.sv
verif/tb_triple_buffer_frame_mailbox.sv
